>>> sv/maf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// maf_pkg
// Shared constants and types for the boxcar moving-average filter.
// ----------------------------------------------------------------------------
package maf_pkg;

    // Window length register.
    localparam int CFG_W = 9;
    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    // Defaults for the top-level parameters.
    localparam int MAX_WINDOW_DEF   = 256;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // Top-level sequencer.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE
    } maf_state_t;

endpackage
`default_nettype wire

>>> sv/maf_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// maf_in_if
// Sample channel: valid/ready with one sample and its start-of-sequence flag.
// ----------------------------------------------------------------------------
interface maf_in_if #(
    parameter int SAMPLE_WIDTH = maf_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           first_of_sequence;

    modport source (
        output valid,
        output sample,
        output first_of_sequence,
        input  ready
    );

    modport sink (
        input  valid,
        input  sample,
        input  first_of_sequence,
        output ready
    );
endinterface
`default_nettype wire

>>> sv/maf_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// maf_out_if
// Result channel: valid/ready with one window average.
// ----------------------------------------------------------------------------
interface maf_out_if #(
    parameter int SAMPLE_WIDTH = maf_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] average;

    modport source (
        output valid,
        output average,
        input  ready
    );

    modport sink (
        input  valid,
        input  average,
        output ready
    );
endinterface
`default_nettype wire

>>> sv/maf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// maf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module maf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> sv/maf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// maf_div
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module maf_div #(
    parameter int SUM_W = 40,
    parameter int DIV_W = 9,
    parameter int Q_W   = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [SUM_W-1:0] dividend,
    input  wire logic        [DIV_W-1:0] divisor,
    output logic                         done,
    output logic signed      [Q_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             busy_reg,  busy_next;
    logic             done_reg,  done_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             neg_reg,   neg_next;
    logic [SUM_W-1:0] q_reg,     q_next;
    logic [DIV_W-1:0] rem_reg,   rem_next;
    logic [DIV_W-1:0] dvs_reg,   dvs_next;

    logic [DIV_W:0]   shifted;
    logic             ge;
    logic [SUM_W-1:0] q_signed;

    always_comb
    begin
        shifted   = {rem_reg, q_reg[SUM_W-1]};
        ge        = (shifted >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = CNT_W'(SUM_W);
            neg_next  = dividend[SUM_W-1];
            // magnitude of the most negative sum still fits unsigned
            q_next    = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DIV_W'(shifted - {1'b0, dvs_reg}) : shifted[DIV_W-1:0];
            q_next   = {q_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign q_signed = neg_reg ? (~q_reg + 1'b1) : q_reg;
    assign quotient = q_signed[Q_W-1:0];
    assign done     = done_reg;

endmodule
`default_nettype wire

>>> sv/moving_average_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// moving_average_filter
// Boxcar moving average over a ring of recent samples held in one RAM.
// ----------------------------------------------------------------------------
// Samples are taken one at a time. An accepted beat reads the oldest window
// entry from the sample RAM, and in the next cycle the running sum is updated
// and the new sample is written back. A sample that completes a window then
// goes through a restoring divider at one quotient bit per cycle, and its
// average is loaded into the result register once the divider is done and
// the result register is free. The divider and back-pressure on the result
// channel set the rate. The result register holds a finished average while
// the next sample is accepted. Writing window_length (cfg_we/cfg_wdata)
// restarts the sequence; the user must write it only while idle, which the
// block does not enforce. 0 acts as 1 and lengths above MAX_WINDOW act as MAX_WINDOW.
// ----------------------------------------------------------------------------
module moving_average_filter #(
    parameter int MAX_WINDOW   = maf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = maf_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [maf_pkg::CFG_W-1:0]  cfg_wdata,
    maf_in_if.sink                          in_ch,
    maf_out_if.source                       out_ch
);

    localparam int CFG_W = maf_pkg::CFG_W;
    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int SUM_W = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
    localparam int OFF_W = ((PTR_W > CFG_W) ? PTR_W : CFG_W) + 1;

    maf_pkg::maf_state_t state_reg, state_next;

    logic [CFG_W-1:0]               window_length_reg;
    logic [CFG_W-1:0]               fill_count_reg;
    logic signed [SUM_W-1:0]        sum_reg;
    logic [PTR_W-1:0]               wp_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                           full_reg;
    logic                           emit_reg;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] average_reg;

    logic                    in_ready;
    logic                    accept;
    logic                    ram_re;
    logic                    ram_we;
    logic                    div_start;
    logic                    out_load;

    logic [CFG_W-1:0]        len_eff;
    logic [CFG_W-1:0]        fill_base;
    logic                    full_now;
    logic [OFF_W-1:0]        wp_x;
    logic [OFF_W-1:0]        len_x;
    logic [OFF_W-1:0]        diff;
    logic [PTR_W-1:0]        oldest;
    logic [PTR_W-1:0]        wp_inc;
    logic [SAMPLE_WIDTH-1:0] ram_rdata;
    logic signed [SUM_W-1:0] old_ext;
    logic signed [SUM_W-1:0] new_ext;
    logic signed [SUM_W-1:0] sum_next;
    logic                    div_done;
    logic signed [SAMPLE_WIDTH-1:0] div_q;

    // effective window length
    always_comb
    begin
        if (window_length_reg == '0)
        begin
            len_eff = CFG_W'(1);
        end
        else if (int'(window_length_reg) > MAX_WINDOW)
        begin
            len_eff = CFG_W'(MAX_WINDOW);
        end
        else
        begin
            len_eff = window_length_reg;
        end
    end

    assign fill_base = in_ch.first_of_sequence ? '0 : fill_count_reg;
    assign full_now  = (fill_base >= len_eff);

    // oldest entry of the window, modulo the ring depth
    always_comb
    begin
        wp_x  = OFF_W'(wp_reg);
        len_x = OFF_W'(len_eff);
        diff  = wp_x - len_x;
        if (wp_x < len_x)
        begin
            diff = diff + OFF_W'(MAX_WINDOW);
        end
        oldest = diff[PTR_W-1:0];
    end

    assign wp_inc = (int'(wp_reg) == MAX_WINDOW - 1) ? '0 : wp_reg + 1'b1;

    assign old_ext  = SUM_W'(signed'(ram_rdata));
    assign new_ext  = SUM_W'(sample_reg);
    assign sum_next = sum_reg + new_ext - (full_reg ? old_ext : '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            maf_pkg::ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = maf_pkg::ST_UPDATE;
                end
            end
            maf_pkg::ST_UPDATE:
            begin
                state_next = emit_reg ? maf_pkg::ST_DIVIDE : maf_pkg::ST_IDLE;
            end
            maf_pkg::ST_DIVIDE:
            begin
                if (div_done && (!out_valid_reg || out_ch.ready))
                begin
                    state_next = maf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = maf_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            maf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            maf_pkg::ST_UPDATE:
            begin
                ram_we    = 1'b1;
                div_start = emit_reg;
            end
            maf_pkg::ST_DIVIDE:
            begin
                out_load = div_done && (!out_valid_reg || out_ch.ready);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept = in_ch.valid && in_ready;
    assign ram_re = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= maf_pkg::ST_IDLE;
            window_length_reg <= maf_pkg::CFG_RESET;
            fill_count_reg    <= '0;
            sum_reg           <= '0;
            wp_reg            <= '0;
            full_reg          <= 1'b0;
            emit_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                fill_count_reg <= full_now ? len_eff : fill_base + CFG_W'(1);
                full_reg       <= full_now;
                emit_reg       <= full_now || ((fill_base + CFG_W'(1)) >= len_eff);
                if (in_ch.first_of_sequence)
                begin
                    sum_reg <= '0;
                end
            end
            if (ram_we)
            begin
                sum_reg <= sum_next;
                wp_reg  <= wp_inc;
            end
            if (cfg_we)
            begin
                window_length_reg <= cfg_wdata;
                fill_count_reg    <= '0;
                sum_reg           <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= in_ch.sample;
        end
        if (out_load)
        begin
            average_reg <= div_q;
        end
    end

    maf_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (sample_reg),
        .re    (ram_re),
        .raddr (oldest),
        .rdata (ram_rdata)
    );

    maf_div #(
        .SUM_W (SUM_W),
        .DIV_W (CFG_W),
        .Q_W   (SAMPLE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (len_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_ch.ready    = in_ready;
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.average = average_reg;

`ifndef SYNTHESIS
    // the window never holds more samples than its length
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= len_eff)
        else $error("fill count exceeds window length");

    // an empty window carries no sum
    a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_count_reg == '0) |-> (sum_reg == '0))
        else $error("nonzero sum with empty window");

    // one sample in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("second sample accepted while one is in flight");

    // ring pointer stays inside the ring
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(wp_reg) < MAX_WINDOW)
        else $error("write pointer out of ring range");

    // a loaded result is presented next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("loaded average not presented");
`endif

endmodule
`default_nettype wire
